// ===== design/pcx_rle_pkg.sv =====
// Shared types and constants for the PCX run-length plane decoder.
// Used by pcx_rle_ctrl, pcx_rle_datapath and pcx_rle_plane_decoder; no dependencies.
package pcx_rle_pkg;

    // Default screen geometry and row offset
    localparam int ROW_OFFSET_DEFAULT    = 18;
    localparam int SCREEN_WIDTH_DEFAULT  = 640;
    localparam int SCREEN_HEIGHT_DEFAULT = 400;

    // Run marker: both top bits set, run count in the low six bits
    localparam logic [7:0] MARKER_MASK = 8'hC0;

    // Configuration register indexes
    localparam logic [2:0] CFG_FIRST_COLUMN_BYTE = 3'd0;
    localparam logic [2:0] CFG_FIRST_ROW         = 3'd1;
    localparam logic [2:0] CFG_LAST_ROW          = 3'd2;
    localparam logic [2:0] CFG_BYTES_PER_LINE    = 3'd3;
    localparam logic [2:0] CFG_PLANE_COUNT       = 3'd4;

    // Configuration reset values
    localparam logic [12:0] FIRST_COLUMN_BYTE_RST = 13'd0;
    localparam logic [15:0] FIRST_ROW_RST         = 16'd0;
    localparam logic [15:0] LAST_ROW_RST          = 16'd111;
    localparam logic [15:0] BYTES_PER_LINE_RST    = 16'd14;
    localparam logic [2:0]  PLANE_COUNT_RST       = 3'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;   // take the input beat
        logic step;     // place one decoded byte
        logic flush;    // move the held result out, marked last
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic start_run;   // the current input beat starts a run of one or more
        logic step_last;   // the next step ends the run
        logic hold_valid;  // a result waits in the hold stage
        logic out_free;    // the output register can take a result this cycle
    } dp_status_t;

    typedef struct packed {
        logic [6:0] column_byte;
        logic [8:0] screen_row;
        logic [1:0] plane_index;
        logic [7:0] pixel_bits;
        logic       last_of_run;
        logic       finished;
    } result_t;

endpackage

// ===== design/pcx_rle_ctrl.sv =====
// Controller state machine of the PCX run-length plane decoder.
// Depends on pcx_rle_pkg; drives commands into pcx_rle_datapath.
module pcx_rle_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  pcx_rle_pkg::dp_status_t sts,
    output pcx_rle_pkg::ctrl_cmd_t  cmd
);

    pcx_rle_pkg::ctrl_state_t state_reg;
    pcx_rle_pkg::ctrl_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcx_rle_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence accept, per-byte steps and the final flush
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            pcx_rle_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid && sts.start_run)
                begin
                    state_next = pcx_rle_pkg::ST_RUN;
                end
            end
            pcx_rle_pkg::ST_RUN:
            begin
                // step only when a displaced held result has somewhere to go
                cmd.step = !sts.hold_valid || sts.out_free;
                if (cmd.step && sts.step_last)
                begin
                    state_next = pcx_rle_pkg::ST_FLUSH;
                end
            end
            pcx_rle_pkg::ST_FLUSH:
            begin
                cmd.flush = sts.hold_valid && sts.out_free;
                if (!sts.hold_valid || sts.out_free)
                begin
                    state_next = pcx_rle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcx_rle_pkg::ST_IDLE;
            end
        endcase
    end

    // No result may be left held once a new beat can be taken
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcx_rle_pkg::ST_IDLE) |-> !sts.hold_valid)
        else $error("held result left behind in idle");

    // The step that ends a run always leads to the flush
    a_last_step_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && sts.step_last) |=> (state_reg == pcx_rle_pkg::ST_FLUSH))
        else $error("run ended without flush");

endmodule

// ===== design/pcx_rle_datapath.sv =====
// Datapath of the PCX run-length plane decoder: config, position counters,
// run stepper, hold stage and output register. Depends on pcx_rle_pkg.
module pcx_rle_datapath
#(
    parameter int ROW_OFFSET    = pcx_rle_pkg::ROW_OFFSET_DEFAULT,
    parameter int SCREEN_WIDTH  = pcx_rle_pkg::SCREEN_WIDTH_DEFAULT,
    parameter int SCREEN_HEIGHT = pcx_rle_pkg::SCREEN_HEIGHT_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic [7:0]              stream_byte,
    input  pcx_rle_pkg::ctrl_cmd_t  cmd,
    output pcx_rle_pkg::dp_status_t sts,
    output logic                    out_valid,
    input  logic                    out_stall,
    output pcx_rle_pkg::result_t    out_res
);

    localparam logic [15:0] VIS_COLS = 16'(SCREEN_WIDTH / 8);
    localparam logic [16:0] VIS_ROWS = 17'(SCREEN_HEIGHT - 2);
    localparam logic [16:0] ROW_OFS  = 17'(ROW_OFFSET);

    // Configuration
    logic [12:0] first_col_reg,  first_col_next;
    logic [15:0] first_row_reg,  first_row_next;
    logic [15:0] last_row_reg,   last_row_next;
    logic [15:0] bpl_reg,        bpl_next;
    logic [2:0]  planes_reg,     planes_next;

    // Frame and run state
    logic [5:0]  pending_reg,    pending_next;
    logic        awaiting_reg,   awaiting_next;
    logic [15:0] column_reg,     column_next;
    logic [15:0] row_reg,        row_next;
    logic [1:0]  plane_reg,      plane_next;
    logic        done_reg,       done_next;
    logic [5:0]  run_left_reg,   run_left_next;
    logic        hold_valid_reg, hold_valid_next;
    logic        out_valid_reg,  out_valid_next;

    // Payload
    logic [7:0]           data_reg;
    pcx_rle_pkg::result_t hold_reg;
    pcx_rle_pkg::result_t out_reg;
    pcx_rle_pkg::result_t out_next;

    // Step terms
    logic                 is_marker;
    logic                 restart;
    logic [2:0]           planes_eff;
    logic [15:0]          rel;
    logic                 wrap;
    logic [2:0]           plane_inc;
    logic                 row_adv;
    logic [16:0]          row_inc;
    logic                 finish;
    logic [1:0]           plane_new;
    logic [15:0]          row_new;
    logic [15:0]          col_place;
    logic [16:0]          srow;
    logic                 emit;
    logic                 out_taken;
    logic                 out_load;
    pcx_rle_pkg::result_t step_res;

    assign is_marker = (stream_byte & pcx_rle_pkg::MARKER_MASK) == pcx_rle_pkg::MARKER_MASK;
    assign restart   = cfg_we && (cfg_index <= pcx_rle_pkg::CFG_PLANE_COUNT);
    assign out_taken = out_valid_reg && !out_stall;

    // Clamp the plane count to one through four
    always_comb
    begin
        case (planes_reg)
            3'd0:    planes_eff = 3'd1;
            3'd1:    planes_eff = 3'd1;
            3'd2:    planes_eff = 3'd2;
            3'd3:    planes_eff = 3'd3;
            3'd4:    planes_eff = 3'd4;
            default: planes_eff = 3'd4;
        endcase
    end

    // Place one decoded byte: wrap the line, advance plane and row, test window
    always_comb
    begin
        rel       = column_reg - {3'd0, first_col_reg};
        wrap      = rel >= bpl_reg;
        plane_inc = {1'b0, plane_reg} + 3'd1;
        row_adv   = wrap && (plane_inc >= planes_eff);
        row_inc   = {1'b0, row_reg} + 17'd1;
        finish    = row_adv && (row_inc > {1'b0, last_row_reg});
        plane_new = row_adv ? 2'd0 : (wrap ? plane_inc[1:0] : plane_reg);
        row_new   = row_adv ? row_inc[15:0] : row_reg;
        col_place = wrap ? (column_reg - bpl_reg) : column_reg;
        srow      = {1'b0, row_new} + ROW_OFS;
        emit      = finish || ((col_place < VIS_COLS) && (srow < VIS_ROWS));

        step_res = '0;
        if (finish)
        begin
            step_res.finished = 1'b1;
        end
        else
        begin
            step_res.column_byte = col_place[6:0];
            step_res.screen_row  = srow[8:0];
            step_res.plane_index = plane_new;
            step_res.pixel_bits  = data_reg;
        end
    end

    // Status toward the controller
    always_comb
    begin
        sts.start_run  = !done_reg && (awaiting_reg ? (pending_reg != 6'd0) : !is_marker);
        sts.step_last  = (run_left_reg == 6'd1) || finish;
        sts.hold_valid = hold_valid_reg;
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_load = (cmd.step && emit && hold_valid_reg) || cmd.flush;

    // Mark the beat that leaves on a flush as the last of its input
    always_comb
    begin
        out_next             = hold_reg;
        out_next.last_of_run = cmd.flush;
    end

    // Next values of config and control state
    always_comb
    begin
        first_col_next  = first_col_reg;
        first_row_next  = first_row_reg;
        last_row_next   = last_row_reg;
        bpl_next        = bpl_reg;
        planes_next     = planes_reg;
        pending_next    = pending_reg;
        awaiting_next   = awaiting_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        plane_next      = plane_reg;
        done_next       = done_reg;
        run_left_next   = run_left_reg;
        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg;

        // Advance the output register
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_taken)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.flush)
        begin
            hold_valid_next = 1'b0;
        end

        // Decode the input beat
        if (cmd.accept && !done_reg)
        begin
            if (awaiting_reg)
            begin
                run_left_next = pending_reg;
                awaiting_next = 1'b0;
                pending_next  = 6'd0;
            end
            else if (is_marker)
            begin
                pending_next  = stream_byte[5:0];
                awaiting_next = 1'b1;
            end
            else
            begin
                run_left_next = 6'd1;
            end
        end

        // Place one byte of the run
        if (cmd.step)
        begin
            run_left_next = run_left_reg - 6'd1;
            plane_next    = plane_new;
            row_next      = row_new;
            if (finish)
            begin
                done_next = 1'b1;
            end
            else
            begin
                column_next = col_place + 16'd1;
            end
            if (emit)
            begin
                hold_valid_next = 1'b1;
            end
        end

        // Write a register and restart the frame
        if (restart)
        begin
            case (cfg_index)
                pcx_rle_pkg::CFG_FIRST_COLUMN_BYTE: first_col_next = cfg_data[12:0];
                pcx_rle_pkg::CFG_FIRST_ROW:         first_row_next = cfg_data;
                pcx_rle_pkg::CFG_LAST_ROW:          last_row_next  = cfg_data;
                pcx_rle_pkg::CFG_BYTES_PER_LINE:    bpl_next       = cfg_data;
                pcx_rle_pkg::CFG_PLANE_COUNT:       planes_next    = cfg_data[2:0];
                default:                            planes_next    = planes_reg;
            endcase
            pending_next  = 6'd0;
            awaiting_next = 1'b0;
            column_next   = {3'd0, first_col_next};
            row_next      = first_row_next;
            plane_next    = 2'd0;
            done_next     = 1'b0;
        end
    end

    // Hold config and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_col_reg  <= pcx_rle_pkg::FIRST_COLUMN_BYTE_RST;
            first_row_reg  <= pcx_rle_pkg::FIRST_ROW_RST;
            last_row_reg   <= pcx_rle_pkg::LAST_ROW_RST;
            bpl_reg        <= pcx_rle_pkg::BYTES_PER_LINE_RST;
            planes_reg     <= pcx_rle_pkg::PLANE_COUNT_RST;
            pending_reg    <= 6'd0;
            awaiting_reg   <= 1'b0;
            column_reg     <= {3'd0, pcx_rle_pkg::FIRST_COLUMN_BYTE_RST};
            row_reg        <= pcx_rle_pkg::FIRST_ROW_RST;
            plane_reg      <= 2'd0;
            done_reg       <= 1'b0;
            run_left_reg   <= 6'd0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            first_col_reg  <= first_col_next;
            first_row_reg  <= first_row_next;
            last_row_reg   <= last_row_next;
            bpl_reg        <= bpl_next;
            planes_reg     <= planes_next;
            pending_reg    <= pending_next;
            awaiting_reg   <= awaiting_next;
            column_reg     <= column_next;
            row_reg        <= row_next;
            plane_reg      <= plane_next;
            done_reg       <= done_next;
            run_left_reg   <= run_left_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload: data byte, hold stage and output register
    always_ff @(posedge clk)
    begin
        if (cmd.accept && !done_reg && (awaiting_reg || !is_marker))
        begin
            data_reg <= stream_byte;
        end
        if (cmd.step && emit)
        begin
            hold_reg <= step_res;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // A held result is only pushed out when the output register can take it
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten");

    // Flush only moves a result that is really held
    a_flush_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> hold_valid_reg)
        else $error("flush with empty hold stage");

    // Once finished, the frame stays finished until a register write
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !restart) |=> done_reg)
        else $error("finished flag dropped without restart");

endmodule

// ===== design/pcx_rle_plane_decoder.sv =====
// Top level of the PCX run-length plane decoder.
// Depends on pcx_rle_pkg, pcx_rle_ctrl and pcx_rle_datapath.
//
// Takes encoded PCX image bytes one beat at a time and issues screen writes
// (byte column, screen row, plane, eight pixels) for bytes that land inside
// the visible window, with last_of_run on the final write of each input beat
// and a single finished write once the row passes last_row; after that every
// beat is taken and dropped. A run marker beat, a run-count-zero data beat and
// any beat after finishing are taken without leaving idle. A literal or a run
// is accepted in idle; the stepper then places one byte column per cycle,
// and the flush state hands the last write to the output register before
// the next accept. The output register lets the next beat be taken while a
// write still waits; a stalled output holds the stepper.
// Any register write restarts the frame; cfg_ready is always high.
module pcx_rle_plane_decoder
#(
    parameter int ROW_OFFSET    = pcx_rle_pkg::ROW_OFFSET_DEFAULT,
    parameter int SCREEN_WIDTH  = pcx_rle_pkg::SCREEN_WIDTH_DEFAULT,
    parameter int SCREEN_HEIGHT = pcx_rle_pkg::SCREEN_HEIGHT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  column_byte,
    output logic [8:0]  screen_row,
    output logic [1:0]  plane_index,
    output logic [7:0]  pixel_bits,
    output logic        last_of_run,
    output logic        finished
);

    pcx_rle_pkg::ctrl_cmd_t  cmd;
    pcx_rle_pkg::dp_status_t sts;
    pcx_rle_pkg::result_t    res;

    assign cfg_ready = 1'b1;

    pcx_rle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pcx_rle_datapath
    #(
        .ROW_OFFSET    (ROW_OFFSET),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .stream_byte (stream_byte),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_res     (res)
    );

    // Split the result beat onto its ports
    assign column_byte = res.column_byte;
    assign screen_row  = res.screen_row;
    assign plane_index = res.plane_index;
    assign pixel_bits  = res.pixel_bits;
    assign last_of_run = res.last_of_run;
    assign finished    = res.finished;

endmodule
